FILE: src/segment_triangle_intersection_assert.svh
// Assertion macros shared by the segment / triangle classifier.
`ifndef SEGMENT_TRIANGLE_INTERSECTION_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECTION_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define STI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sti_pkg.sv
package sti_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned NumCfgRegs = 6;
  localparam int unsigned HitBits = 4;
  localparam int unsigned FifoDepth = 8;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStartX = 3'd0,
    CfgStartY = 3'd1,
    CfgStartZ = 3'd2,
    CfgEndX   = 3'd3,
    CfgEndY   = 3'd4,
    CfgEndZ   = 3'd5
  } cfg_idx_e;

  typedef enum logic [HitBits-1:0] {
    HcMiss        = 4'd0,
    HcCoplanar    = 4'd1,
    HcEndVertex   = 4'd2,
    HcEndEdge     = 4'd3,
    HcEndFace     = 4'd4,
    HcCrossFace   = 4'd5,
    HcCrossEdge   = 4'd6,
    HcCrossVertex = 4'd7,
    HcDegenerate  = 4'd8
  } hit_code_e;

  // Which classification the back part has to carry out.
  typedef enum logic [1:0] {
    KindFixed = 2'd0,
    KindCross = 2'd1,
    KindPoint = 2'd2
  } kind_e;

  // Signs as two bits: positive, negative.
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  function automatic hit_code_e classify_point(sgn_t s0, sgn_t s1, sgn_t s2);
    logic z0, z1, z2;
    logic [1:0] zeros;
    logic allp, alln, anyp, anyn;
    begin
      z0 = !s0.pos && !s0.neg;
      z1 = !s1.pos && !s1.neg;
      z2 = !s2.pos && !s2.neg;
      zeros = {1'b0, z0} + {1'b0, z1} + {1'b0, z2};
      allp = s0.pos && s1.pos && s2.pos;
      alln = s0.neg && s1.neg && s2.neg;
      anyp = s0.pos || s1.pos || s2.pos;
      anyn = s0.neg || s1.neg || s2.neg;
      if (zeros == 2'd1 && !(anyp && anyn)) begin
        classify_point = HcEndEdge;
      end else if (allp || alln) begin
        classify_point = HcEndFace;
      end else if (zeros == 2'd3) begin
        classify_point = HcDegenerate;
      end else if (zeros == 2'd2) begin
        classify_point = HcEndVertex;
      end else begin
        classify_point = HcMiss;
      end
    end
  endfunction

  function automatic hit_code_e classify_cross(sgn_t s0, sgn_t s1, sgn_t s2);
    logic z0, z1, z2;
    logic [1:0] zeros;
    logic anyp, anyn;
    begin
      z0 = !s0.pos && !s0.neg;
      z1 = !s1.pos && !s1.neg;
      z2 = !s2.pos && !s2.neg;
      zeros = {1'b0, z0} + {1'b0, z1} + {1'b0, z2};
      anyp = s0.pos || s1.pos || s2.pos;
      anyn = s0.neg || s1.neg || s2.neg;
      if ((s0.pos && s1.pos && s2.pos) || (s0.neg && s1.neg && s2.neg)) begin
        classify_cross = HcCrossFace;
      end else if (anyp && anyn) begin
        classify_cross = HcMiss;
      end else if (zeros == 2'd2) begin
        classify_cross = HcCrossVertex;
      end else if (zeros == 2'd1) begin
        classify_cross = HcCrossEdge;
      end else begin
        classify_cross = HcDegenerate;
      end
    end
  endfunction

endpackage

FILE: src/sti_front.sv
// Front part: plane normal, numerator and denominator, and which test
// follows. Four register stages; takes an item per cycle while en_i is high.
module sti_front #(
  parameter int unsigned CoordBits = sti_pkg::CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 en_i,
  input  logic signed [CoordBits-1:0] a_i [3],
  input  logic signed [CoordBits-1:0] b_i [3],
  input  logic signed [CoordBits-1:0] c_i [3],
  input  logic signed [CoordBits-1:0] q_i [3],
  input  logic signed [CoordBits-1:0] r_i [3],
  output logic                 out_valid_o,
  output sti_pkg::kind_e       kind_o,
  output sti_pkg::hit_code_e   fixed_o,
  output logic                 use_r_o,
  output logic [1:0]           drop_o,
  output logic signed [CoordBits-1:0] a_o [3],
  output logic signed [CoordBits-1:0] b_o [3],
  output logic signed [CoordBits-1:0] c_o [3]
);
  import sti_pkg::*;

  localparam int unsigned DW = CoordBits + 1;      // differences
  localparam int unsigned PW = 2 * DW;             // products
  localparam int unsigned NW = PW + 1;             // normal
  localparam int unsigned SW = NW + DW + 2;        // dot products

  logic [3:0] v_q;
  logic signed [CoordBits-1:0] a1_q [3], b1_q [3], c1_q [3];
  logic signed [CoordBits-1:0] a2_q [3], b2_q [3], c2_q [3];
  logic signed [CoordBits-1:0] a3_q [3], b3_q [3], c3_q [3];
  logic signed [CoordBits-1:0] a4_q [3], b4_q [3], c4_q [3];
  logic signed [DW-1:0] ab1_q [3], ac1_q [3], aq1_q [3], rq1_q [3];
  logic signed [DW-1:0] aq2_q [3], rq2_q [3];
  logic signed [PW-1:0] pp2_q [6];
  logic signed [NW-1:0] n_d [3], n3_q [3];
  logic signed [PW+DW-1:0] tn3_q [3], td3_q [3];
  logic signed [SW-1:0] num_d, den_d;
  logic [1:0] drop_d, drop4_q;
  logic signed [NW-1:0] m0, m1, m2;
  kind_e kind_d, kind4_q;
  hit_code_e fixed_d, fixed4_q;
  logic use_r_d, use_r4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = NW'(pp2_q[2*i]) - NW'(pp2_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i] <= a_i[i]; b1_q[i] <= b_i[i]; c1_q[i] <= c_i[i];
        ab1_q[i] <= DW'(b_i[i]) - DW'(a_i[i]);
        ac1_q[i] <= DW'(c_i[i]) - DW'(a_i[i]);
        aq1_q[i] <= DW'(a_i[i]) - DW'(q_i[i]);
        rq1_q[i] <= DW'(r_i[i]) - DW'(q_i[i]);
        a2_q[i] <= a1_q[i]; b2_q[i] <= b1_q[i]; c2_q[i] <= c1_q[i];
        aq2_q[i] <= aq1_q[i]; rq2_q[i] <= rq1_q[i];
        a3_q[i] <= a2_q[i]; b3_q[i] <= b2_q[i]; c3_q[i] <= c2_q[i];
        n3_q[i] <= n_d[i];
        tn3_q[i] <= aq2_q[i] * n_d[i];
        td3_q[i] <= rq2_q[i] * n_d[i];
        a4_q[i] <= a3_q[i]; b4_q[i] <= b3_q[i]; c4_q[i] <= c3_q[i];
      end
      pp2_q[0] <= ab1_q[1] * ac1_q[2];
      pp2_q[1] <= ab1_q[2] * ac1_q[1];
      pp2_q[2] <= ab1_q[2] * ac1_q[0];
      pp2_q[3] <= ab1_q[0] * ac1_q[2];
      pp2_q[4] <= ab1_q[0] * ac1_q[1];
      pp2_q[5] <= ab1_q[1] * ac1_q[0];
      kind4_q <= kind_d;
      fixed4_q <= fixed_d;
      use_r4_q <= use_r_d;
      drop4_q <= drop_d;
    end
  end

  // Stage four: sums, sign decisions and the projection axis.
  always_comb begin
    num_d = SW'(tn3_q[0]) + SW'(tn3_q[1]) + SW'(tn3_q[2]);
    den_d = SW'(td3_q[0]) + SW'(td3_q[1]) + SW'(td3_q[2]);
    m0 = n3_q[0][NW-1] ? -n3_q[0] : n3_q[0];
    m1 = n3_q[1][NW-1] ? -n3_q[1] : n3_q[1];
    m2 = n3_q[2][NW-1] ? -n3_q[2] : n3_q[2];
    drop_d = 2'd0;
    if (m1 > m0) begin
      drop_d = 2'd1;
      if (m2 > m1) drop_d = 2'd2;
    end else if (m2 > m0) begin
      drop_d = 2'd2;
    end
    kind_d = KindFixed;
    fixed_d = HcMiss;
    use_r_d = 1'b0;
    if (den_d == '0) begin
      fixed_d = (num_d == '0) ? HcCoplanar : HcMiss;
    end else if ((den_d > 0 && num_d > 0 && num_d < den_d) ||
                 (den_d < 0 && num_d < 0 && num_d > den_d)) begin
      kind_d = KindCross;
    end else if (num_d == '0) begin
      kind_d = KindPoint;
    end else if (num_d == den_d) begin
      kind_d = KindPoint;
      use_r_d = 1'b1;
    end
  end

  assign out_valid_o = v_q[3];
  assign kind_o = kind4_q;
  assign fixed_o = fixed4_q;
  assign use_r_o = use_r4_q;
  assign drop_o = drop4_q;
  assign a_o = a4_q;
  assign b_o = b4_q;
  assign c_o = c4_q;

endmodule

FILE: src/sti_fifo.sv
// Small queue between the front and back parts.
module sti_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = sti_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

FILE: src/sti_back.sv
// Back part: tetrahedron volumes or 2D areas, then the final code.
// Two register stages followed by the output register.
module sti_back #(
  parameter int unsigned CoordBits = sti_pkg::CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sti_pkg::kind_e       kind_i,
  input  sti_pkg::hit_code_e   fixed_i,
  input  logic                 use_r_i,
  input  logic [1:0]           drop_i,
  input  logic signed [CoordBits-1:0] a_i [3],
  input  logic signed [CoordBits-1:0] b_i [3],
  input  logic signed [CoordBits-1:0] c_i [3],
  input  logic signed [CoordBits-1:0] q_i [3],
  input  logic signed [CoordBits-1:0] r_i [3],
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sti_pkg::hit_code_e   hit_code_o
);
  import sti_pkg::*;

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned VW = CW + DW + 2;

  logic [1:0] v_q;
  logic en;
  kind_e kind1_q, kind2_q;
  hit_code_e fixed1_q, fixed2_q;
  logic signed [CoordBits-1:0] p [3];
  logic signed [DW-1:0] ua [3], ub [3], uc [3], dq;
  logic signed [DW-1:0] ea_q [3], eb_q [3], ec_q [3];
  logic signed [DW-1:0] pa_q [2], pb_q [2], pc_q [2];
  logic signed [CW-1:0] cab, cbc, cca;
  logic signed [VW-1:0] t_ab [3], t_bc [3], t_ca [3];
  logic signed [PW-1:0] x2_q [6];
  logic signed [VW-1:0] vsum [3];
  logic signed [CW-1:0] ar [3];
  sgn_t s [3];
  hit_code_e code_d;
  hit_code_e code_q;
  logic ov_q;
  logic [1:0] ax0, ax1;
  logic signed [DW-1:0] r0, r1, r2;

  assign en = !ov_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q <= {v_q[0], in_valid_i};
      ov_q <= v_q[1];
    end
  end

  // Stage one: differences relative to the end point R, and the projected
  // coordinates, relative to the chosen endpoint, for the point test.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = use_r_i ? r_i[i] : q_i[i];
    end
    ax0 = (drop_i == 2'd0) ? 2'd1 : 2'd0;
    ax1 = (drop_i == 2'd2) ? 2'd1 : 2'd2;
    for (int i = 0; i < 3; i++) begin
      dq = DW'(q_i[i]) - DW'(r_i[i]);
      ua[i] = DW'(a_i[i]) - DW'(r_i[i]);
      ub[i] = DW'(b_i[i]) - DW'(r_i[i]);
      uc[i] = DW'(c_i[i]) - DW'(r_i[i]);
      if (i == 0) r0 = dq;
      if (i == 1) r1 = dq;
      if (i == 2) r2 = dq;
    end
  end

  logic signed [DW-1:0] qr1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= kind_i;
      fixed1_q <= fixed_i;
      qr1_q[0] <= r0; qr1_q[1] <= r1; qr1_q[2] <= r2;
      for (int i = 0; i < 3; i++) begin
        ea_q[i] <= ua[i]; eb_q[i] <= ub[i]; ec_q[i] <= uc[i];
      end
      pa_q[0] <= DW'(a_i[ax0]) - DW'(p[ax0]);
      pa_q[1] <= DW'(a_i[ax1]) - DW'(p[ax1]);
      pb_q[0] <= DW'(b_i[ax0]) - DW'(p[ax0]);
      pb_q[1] <= DW'(b_i[ax1]) - DW'(p[ax1]);
      pc_q[0] <= DW'(c_i[ax0]) - DW'(p[ax0]);
      pc_q[1] <= DW'(c_i[ax1]) - DW'(p[ax1]);
    end
  end

  // Stage two: the volumes use the cross product of a pair of edge vectors,
  // dotted with the segment; form the cross products and 2D products.
  logic signed [CW-1:0] cr_q [3][3];
  logic signed [DW-1:0] qr2_q [3];

  function automatic logic signed [CW-1:0] crs(logic signed [DW-1:0] u0,
    logic signed [DW-1:0] u1, logic signed [DW-1:0] w0, logic signed [DW-1:0] w1);
    logic signed [PW-1:0] m0, m1;
    begin
      m0 = u0 * w1;
      m1 = u1 * w0;
      crs = CW'(m0) - CW'(m1);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind2_q <= kind1_q;
      fixed2_q <= fixed1_q;
      qr2_q <= qr1_q;
      // cross (p1 x p2) components for the pairs (a,b), (b,c), (c,a)
      cr_q[0][0] <= crs(ea_q[1], ea_q[2], eb_q[1], eb_q[2]);
      cr_q[0][1] <= crs(ea_q[2], ea_q[0], eb_q[2], eb_q[0]);
      cr_q[0][2] <= crs(ea_q[0], ea_q[1], eb_q[0], eb_q[1]);
      cr_q[1][0] <= crs(eb_q[1], eb_q[2], ec_q[1], ec_q[2]);
      cr_q[1][1] <= crs(eb_q[2], eb_q[0], ec_q[2], ec_q[0]);
      cr_q[1][2] <= crs(eb_q[0], eb_q[1], ec_q[0], ec_q[1]);
      cr_q[2][0] <= crs(ec_q[1], ec_q[2], ea_q[1], ea_q[2]);
      cr_q[2][1] <= crs(ec_q[2], ec_q[0], ea_q[2], ea_q[0]);
      cr_q[2][2] <= crs(ec_q[0], ec_q[1], ea_q[0], ea_q[1]);
      x2_q[0] <= pa_q[0] * pb_q[1];
      x2_q[1] <= pb_q[0] * pa_q[1];
      x2_q[2] <= pb_q[0] * pc_q[1];
      x2_q[3] <= pc_q[0] * pb_q[1];
      x2_q[4] <= pc_q[0] * pa_q[1];
      x2_q[5] <= pa_q[0] * pc_q[1];
    end
  end

  // Stage three: dot with (Q-R), signs and the code.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_ab[k] = qr2_q[k] * cr_q[0][k];
      t_bc[k] = qr2_q[k] * cr_q[1][k];
      t_ca[k] = qr2_q[k] * cr_q[2][k];
    end
    vsum[0] = t_ab[0] + t_ab[1] + t_ab[2];
    vsum[1] = t_bc[0] + t_bc[1] + t_bc[2];
    vsum[2] = t_ca[0] + t_ca[1] + t_ca[2];
    ar[0] = CW'(x2_q[0]) - CW'(x2_q[1]);
    ar[1] = CW'(x2_q[2]) - CW'(x2_q[3]);
    ar[2] = CW'(x2_q[4]) - CW'(x2_q[5]);
    cab = ar[0]; cbc = ar[1]; cca = ar[2];
    unique case (kind2_q)
      KindCross: begin
        for (int k = 0; k < 3; k++) begin
          s[k].pos = !vsum[k][VW-1] && (vsum[k] != '0);
          s[k].neg = vsum[k][VW-1];
        end
        code_d = classify_cross(s[0], s[1], s[2]);
      end
      KindPoint: begin
        s[0] = '{pos: !cab[CW-1] && (cab != '0), neg: cab[CW-1]};
        s[1] = '{pos: !cbc[CW-1] && (cbc != '0), neg: cbc[CW-1]};
        s[2] = '{pos: !cca[CW-1] && (cca != '0), neg: cca[CW-1]};
        code_d = classify_point(s[0], s[1], s[2]);
      end
      default: begin
        s[0] = '0; s[1] = '0; s[2] = '0;
        code_d = fixed2_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o = ov_q;
  assign hit_code_o = code_q;

endmodule

FILE: src/segment_triangle_intersection.sv
// Segment / triangle intersection classifier.
//
// Configuration: write the segment start and end points through the cfg
// channel (cfg_valid_i, cfg_ready_o is always high, cfg_index_i, cfg_data_i)
// while no item is in flight. Indexes 0..2 are the start x, y, z and 3..5 the
// end x, y, z; other indexes are ignored.
// Input: one triangle item per accepted in_valid_i / in_ready_o handshake.
// Output: one hit_code_o item per triangle, in order, on out_valid_o and
// out_ready_i.
// A result passes through the four front stages, the write into the queue and
// three back stages ending in the output register. Throughput is one item
// per cycle; the front part runs freely and the queue absorbs what is in
// flight when the back part stalls on a busy receiver, so in_ready_o falls
// once the queue holds four or more items and rises again as it drains.
// Reset clears the segment to the origin and empties all stages.
module segment_triangle_intersection #(
  parameter int unsigned COORD_BITS = sti_pkg::CoordBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [sti_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [COORD_BITS-1:0] vertex_a_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_a_z_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_b_z_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_c_z_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [3:0] hit_code_o
);
  import sti_pkg::*;

  `include "segment_triangle_intersection_assert.svh"

  localparam int unsigned Depth = FifoDepth;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned FW = 2 + HitBits + 1 + 2 + 9 * COORD_BITS;

  logic signed [COORD_BITS-1:0] q_q [3], r_q [3];
  logic signed [COORD_BITS-1:0] ta [3], tb [3], tc [3];
  logic signed [COORD_BITS-1:0] fa [3], fb [3], fc [3];
  logic signed [COORD_BITS-1:0] ba [3], bb [3], bc [3];
  logic f_valid, b_ready, accept, pop;
  kind_e f_kind, b_kind;
  hit_code_e f_fixed, b_fixed, code;
  logic [1:0] b_kind_raw;
  logic [HitBits-1:0] b_fixed_raw;
  logic f_use_r, b_use_r;
  logic [1:0] f_drop, b_drop;
  logic [FW-1:0] push_data, pop_data;
  logic empty;
  logic [CntW-1:0] count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        q_q[i] <= '0;
        r_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartX: q_q[0] <= cfg_data_i;
        CfgStartY: q_q[1] <= cfg_data_i;
        CfgStartZ: q_q[2] <= cfg_data_i;
        CfgEndX:   r_q[0] <= cfg_data_i;
        CfgEndY:   r_q[1] <= cfg_data_i;
        CfgEndZ:   r_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ta = '{vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
  assign tb = '{vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
  assign tc = '{vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};

  // Admit an item only if the queue has room for everything in the front
  // pipeline plus this item.
  assign in_ready_o = (CntW'(count) + 4'd4 < 5'(Depth)) || (count == '0);
  assign accept = in_valid_i && in_ready_o;

  sti_front #(.CoordBits(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i(accept), .en_i(1'b1),
    .a_i(ta), .b_i(tb), .c_i(tc), .q_i(q_q), .r_i(r_q),
    .out_valid_o(f_valid), .kind_o(f_kind), .fixed_o(f_fixed),
    .use_r_o(f_use_r), .drop_o(f_drop), .a_o(fa), .b_o(fb), .c_o(fc)
  );

  assign push_data = {f_kind, f_fixed, f_use_r, f_drop,
                      fa[0], fa[1], fa[2], fb[0], fb[1], fb[2], fc[0], fc[1], fc[2]};

  sti_fifo #(.Width(FW), .Depth(Depth)) u_fifo (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(push_data), .pop_i(pop),
    .data_o(pop_data), .empty_o(empty), .count_o(count)
  );

  assign {b_kind_raw, b_fixed_raw, b_use_r, b_drop,
          ba[0], ba[1], ba[2], bb[0], bb[1], bb[2], bc[0], bc[1], bc[2]} = pop_data;
  assign b_kind = kind_e'(b_kind_raw);
  assign b_fixed = hit_code_e'(b_fixed_raw);
  assign pop = !empty && b_ready;

  sti_back #(.CoordBits(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .in_valid_i(pop), .in_ready_o(b_ready),
    .kind_i(b_kind), .fixed_i(b_fixed), .use_r_i(b_use_r), .drop_i(b_drop),
    .a_i(ba), .b_i(bb), .c_i(bc), .q_i(q_q), .r_i(r_q),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .hit_code_o(code)
  );

  assign hit_code_o = code;

  `STI_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, f_valid && !pop,
    count < CntW'(Depth), "queue overflow")
  `STI_ASSERT_IMP(a_code_range, clk_i, rst_ni, out_valid_o,
    hit_code_o <= 4'd8, "hit code out of range")
  `STI_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o, "result dropped while stalled")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import sti_pkg::*;

  typedef logic signed [15:0] coord_t;

  // Expected hit codes in order of acceptance, with the mismatch count.
  class hit_scoreboard;
    hit_code_e pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_triangle(hit_code_e code);
      pending.push_back(code);
    endfunction

    task check_hit(logic [3:0] got);
      hit_code_e exp_code;
      if (pending.size() == 0) begin
        report($sformatf("unexpected hit code %0d", got));
      end else begin
        exp_code = pending.pop_front();
        if (got !== exp_code)
          report($sformatf("hit code %0d, expected %0d", got, exp_code));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CoordBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t vertex_a_x_i = '0, vertex_a_y_i = '0, vertex_a_z_i = '0;
  coord_t vertex_b_x_i = '0, vertex_b_y_i = '0, vertex_b_z_i = '0;
  coord_t vertex_c_x_i = '0, vertex_c_y_i = '0, vertex_c_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3:0] hit_code_o;

  segment_triangle_intersection dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .vertex_a_x_i, .vertex_a_y_i, .vertex_a_z_i,
    .vertex_b_x_i, .vertex_b_y_i, .vertex_b_z_i,
    .vertex_c_x_i, .vertex_c_y_i, .vertex_c_z_i,
    .out_valid_o, .out_ready_i, .hit_code_o
  );

  always #5 clk_i = ~clk_i;

  hit_scoreboard sb = new();

  // Our own copy of the segment registers: start x, y, z then end x, y, z.
  coord_t seg[6] = '{default: '0};

  // Idle rates in percent for the sender and the receiver.
  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_req = 1'b0;

  function automatic int sign_of(longint x);
    return (x > 0) - (x < 0);
  endfunction

  // Six times the signed volume of the tetrahedron (p0, p1, p2, p3) relative to p3.
  function automatic longint tet_volume(longint p0[3], longint p1[3],
                                        longint p2[3], longint p3[3]);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    ax = p0[0] - p3[0]; ay = p0[1] - p3[1]; az = p0[2] - p3[2];
    bx = p1[0] - p3[0]; by = p1[1] - p3[1]; bz = p1[2] - p3[2];
    cx = p2[0] - p3[0]; cy = p2[1] - p3[1]; cz = p2[2] - p3[2];
    return az * (bx * cy - by * cx) + ay * (bz * cx - bx * cz)
         + ax * (by * cz - bz * cy);
  endfunction

  // Twice the signed area of the 2D triangle (p, u, v).
  function automatic longint twice_area(longint p[2], longint u[2], longint v[2]);
    return (u[0] - p[0]) * (v[1] - p[1]) - (v[0] - p[0]) * (u[1] - p[1]);
  endfunction

  // An endpoint lying in the triangle's plane: test it in the projection that
  // drops the axis of the largest normal magnitude.
  function automatic hit_code_e point_in_triangle(longint a[3], longint b[3],
      longint c[3], longint pt[3], int drop);
    longint pa[2], pb[2], pc[2], pp[2];
    int j, s0, s1, s2, zeros, sum;
    j = 0;
    for (int i = 0; i < 3; i++) begin
      if (i != drop) begin
        pa[j] = a[i]; pb[j] = b[i]; pc[j] = c[i]; pp[j] = pt[i];
        j++;
      end
    end
    s0 = sign_of(twice_area(pp, pa, pb));
    s1 = sign_of(twice_area(pp, pb, pc));
    s2 = sign_of(twice_area(pp, pc, pa));
    zeros = (s0 == 0) + (s1 == 0) + (s2 == 0);
    sum = s0 + s1 + s2;
    if (zeros == 1 && (sum == 2 || sum == -2)) return HcEndEdge;
    if (zeros == 0 && s0 == s1 && s1 == s2) return HcEndFace;
    if (zeros == 3) return HcDegenerate;
    if (zeros == 2) return HcEndVertex;
    return HcMiss;
  endfunction

  // The segment crosses the plane properly: the three tetrahedron volumes
  // tell on which part of the triangle, if any, it passes through.
  function automatic hit_code_e crossing_kind(longint a[3], longint b[3],
      longint c[3], longint q[3], longint r[3]);
    int s0, s1, s2, zeros;
    bit anypos, anyneg;
    s0 = sign_of(tet_volume(q, a, b, r));
    s1 = sign_of(tet_volume(q, b, c, r));
    s2 = sign_of(tet_volume(q, c, a, r));
    anypos = s0 > 0 || s1 > 0 || s2 > 0;
    anyneg = s0 < 0 || s1 < 0 || s2 < 0;
    zeros = (s0 == 0) + (s1 == 0) + (s2 == 0);
    if (zeros == 0 && s0 == s1 && s1 == s2) return HcCrossFace;
    if (anypos && anyneg) return HcMiss;
    if (zeros == 2) return HcCrossVertex;
    if (zeros == 1) return HcCrossEdge;
    return HcDegenerate;
  endfunction

  function automatic hit_code_e predict_hit(coord_t t[9]);
    longint a[3], b[3], c[3], q[3], r[3], n[3], ab[3], ac[3], mag[3];
    longint num, den;
    int drop;
    for (int i = 0; i < 3; i++) begin
      a[i] = t[i]; b[i] = t[3 + i]; c[i] = t[6 + i];
      q[i] = seg[i]; r[i] = seg[3 + i];
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
    end
    n[0] = ab[1] * ac[2] - ab[2] * ac[1];
    n[1] = ab[2] * ac[0] - ab[0] * ac[2];
    n[2] = ab[0] * ac[1] - ab[1] * ac[0];
    num = (a[0] - q[0]) * n[0] + (a[1] - q[1]) * n[1] + (a[2] - q[2]) * n[2];
    den = (r[0] - q[0]) * n[0] + (r[1] - q[1]) * n[1] + (r[2] - q[2]) * n[2];
    for (int i = 0; i < 3; i++) mag[i] = n[i] < 0 ? -n[i] : n[i];
    drop = 0;
    if (mag[1] > mag[drop]) drop = 1;
    if (mag[2] > mag[drop]) drop = 2;
    if (den == 0) return (num == 0) ? HcCoplanar : HcMiss;
    // Proper crossing means 0 < num/den < 1, decided from the signs and a compare.
    if ((den > 0 && num > 0 && num < den) || (den < 0 && num < 0 && num > den))
      return crossing_kind(a, b, c, q, r);
    if (num == 0) return point_in_triangle(a, b, c, q, drop);
    if (num == den) return point_in_triangle(a, b, c, r, drop);
    return HcMiss;
  endfunction

  // Results are taken at the edge, from values settled before it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_hit(hit_code_o);
  end

  // The receiver: random stalls, and on request one long hold-off so that
  // the internal queue fills and the block has to stall its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Offer one triangle, with random idle cycles first, and hold it until
  // it is taken. The expectation is noted at the accepting edge.
  task automatic send_triangle(coord_t t[9]);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_a_x_i <= t[0]; vertex_a_y_i <= t[1]; vertex_a_z_i <= t[2];
    vertex_b_x_i <= t[3]; vertex_b_y_i <= t[4]; vertex_b_z_i <= t[5];
    vertex_c_x_i <= t[6]; vertex_c_y_i <= t[7]; vertex_c_z_i <= t[8];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_triangle(predict_hit(t));
  endtask

  task automatic send_coords(int ax, int ay, int az, int bx, int by, int bz,
                             int cx, int cy, int cz);
    coord_t t[9];
    t = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
          coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    send_triangle(t);
  endtask

  // Wait until every expected result is in, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CoordBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumCfgRegs) seg[idx] = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load a new segment once the block is idle; indexes beyond the last
  // register are written with junk too, which the block must ignore.
  task automatic set_segment(int qx, int qy, int qz, int rx, int ry, int rz);
    drain();
    write_reg(CfgStartX, coord_t'(qx));
    write_reg(CfgStartY, coord_t'(qy));
    write_reg(CfgStartZ, coord_t'(qz));
    write_reg(CfgEndX, coord_t'(rx));
    write_reg(CfgEndY, coord_t'(ry));
    write_reg(CfgEndZ, coord_t'(rz));
    write_reg(CfgIdxBits'(NumCfgRegs), CoordBits'($urandom));
    write_reg(CfgIdxBits'(NumCfgRegs + 1), CoordBits'($urandom));
  endtask

  function automatic int small_offset();
    return $urandom_range(400) - 200;
  endfunction

  // Random triangle, mostly built around a point of the segment so that
  // crossings and endpoint hits on the face, edges and vertices are common.
  task automatic send_random_triangle();
    coord_t t[9];
    longint p[3], u[3], v[3];
    int mode, shape;
    mode = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      u[i] = small_offset();
      v[i] = small_offset();
      case ($urandom_range(3))
        0: p[i] = seg[i];
        1: p[i] = seg[3 + i];
        default: p[i] = (longint'(seg[i]) + longint'(seg[3 + i])) >>> 1;
      endcase
    end
    if (mode < 15) begin
      foreach (t[i]) t[i] = coord_t'($urandom);
    end else if (mode < 25) begin
      foreach (t[i]) t[i] = coord_t'(small_offset());
    end else if (mode < 35) begin
      // Triangle through both endpoints: the segment lies in its plane.
      for (int i = 0; i < 3; i++) begin
        t[i] = seg[i]; t[3 + i] = seg[3 + i]; t[6 + i] = coord_t'(p[i] + u[i]);
      end
    end else begin
      shape = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
        case (shape)
          0: begin
            t[i] = coord_t'(p[i] + u[i]); t[3 + i] = coord_t'(p[i] + v[i]);
            t[6 + i] = coord_t'(p[i] - u[i] - v[i]);
          end
          1: begin
            t[i] = coord_t'(p[i] + u[i]); t[3 + i] = coord_t'(p[i] - u[i]);
            t[6 + i] = coord_t'(p[i] + v[i]);
          end
          default: begin
            t[i] = coord_t'(p[i]); t[3 + i] = coord_t'(p[i] + u[i]);
            t[6 + i] = coord_t'(p[i] + v[i]);
          end
        endcase
      end
    end
    send_triangle(t);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items on the zero-length segment left by reset.
    send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(10, 0, 0, 0, 10, 0, 0, 0, 10);
    send_coords(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 0);

    // Extremes of the segment and of the vertices.
    set_segment(-32768, -32768, -32768, 32767, 32767, 32767);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768,
                -32768, -32768, -32768);
    send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_coords(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
    send_coords(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768);

    // A segment along z through the origin, for the different kinds of hit.
    set_segment(0, 0, -10, 0, 0, 10);
    send_coords(-10, -10, 0, 10, -10, 0, 0, 10, 0);     // crosses the face
    send_coords(-10, 0, 0, 10, 0, 0, 0, 10, 0);         // crosses an edge
    send_coords(0, 0, 0, 10, 0, 0, 0, 10, 0);           // crosses a vertex
    send_coords(20, 20, 0, 30, 20, 0, 20, 30, 0);       // plane crossed outside
    send_coords(-10, -10, -10, 10, -10, -10, 0, 10, -10); // start point in face
    send_coords(-10, 0, -10, 10, 0, -10, 0, 10, -10);   // start point on edge
    send_coords(0, 0, 10, 10, 0, 10, 0, 10, 10);        // end point on vertex
    send_coords(5, 5, 10, 15, 5, 10, 5, 15, 10);        // end point outside
    send_coords(-10, -10, 30, 10, -10, 30, 0, 10, 30);  // plane beyond the end
    send_coords(-5, 0, -5, 5, 0, -5, 0, 0, 20);         // segment in the plane
    send_coords(1, 1, 1, 2, 2, 2, 3, 3, 3);             // collinear vertices
    send_coords(7, 7, 7, 7, 7, 7, 7, 7, 7);             // single point
    send_coords(0, 0, -10, 0, 0, -10, 5, 5, 5);         // two vertices equal

    // Random phases: sender idles rarely, then receiver rarely, then none.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin tx_idle = 8; rx_idle = 74; end
        1: begin tx_idle = 74; rx_idle = 8; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      if (phase == 5) begin
        set_segment(5, -5, 5, 5, -5, 5);  // zero length away from the origin
      end else begin
        set_segment($urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                    $urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                    $urandom_range(2000) - 1000, $urandom_range(2000) - 1000);
      end
      for (int k = 0; k < 100; k++) begin
        if (phase == 4 && k == 10) hold_req = 1'b1;
        send_random_triangle();
      end
    end
    set_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int k = 0; k < 30; k++) send_random_triangle();

    drain();
    while (sb.pending.size() != 0) begin
      void'(sb.pending.pop_front());
      sb.report("expected hit code never arrived");
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
